>>> hw/rtl/ip6tp_pkg.sv
package ip6tp_pkg;

  localparam int unsigned GroupCount = 8;
  localparam int unsigned GroupWidth = 16;

  typedef logic [GroupWidth-1:0] group_t;

  typedef enum logic [1:0] {
    STATUS_OK      = 2'd0,
    STATUS_BAD     = 2'd1,
    STATUS_TWO_GAP = 2'd2
  } status_t;

  localparam logic [7:0] CHAR_COLON = 8'h3A;

  typedef struct packed {
    logic [7:0] char_code;
    logic       is_final;
  } char_item_t;

  typedef struct packed {
    logic [63:0] address_high;
    logic [63:0] address_low;
    logic [1:0]  status;
  } addr_item_t;

  // Hex digit decode: valid flag and nibble value.
  function automatic logic [4:0] hex_decode(input logic [7:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      r = {1'b1, 4'(c - 8'h30)};
    end else if (c >= 8'h61 && c <= 8'h66) begin
      r = {1'b1, 4'(c - 8'h57)};
    end else if (c >= 8'h41 && c <= 8'h46) begin
      r = {1'b1, 4'(c - 8'h37)};
    end
    return r;
  endfunction

endpackage

>>> hw/rtl/ipv6_text_address_parser.sv
// Channel  | Handshake              | Payload                         | Moves
// -------- | ---------------------- | ------------------------------- | -------------------------
// char     | char_valid, char_ready | char_item (char_code, is_final) | one text character
// addr     | addr_valid, addr_ready | addr_item (address, status)     | one parsed address
//
// One character per cycle unless a final character stalls; state updates on acceptance.
// A final character loads the result register; the address appears in the cycle after.
// The result register parts the two sides: non-final characters are taken while a
// result waits, and a final character stalls only while an untaken result sits there.
// rst is synchronous and active high; it clears the group registers and all flags.
module ipv6_text_address_parser (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   char_valid,
  output logic                   char_ready,
  input  ip6tp_pkg::char_item_t  char_item,
  output logic                   addr_valid,
  input  logic                   addr_ready,
  output ip6tp_pkg::addr_item_t  addr_item
);
  import ip6tp_pkg::*;

  // Parser state.
  group_t      group_store [GroupCount];
  logic [3:0]  group_count;
  logic        prev_was_separator;
  logic        gap_found;
  logic [2:0]  gap_position;
  status_t     error_code;

  group_t      group_store_next [GroupCount];
  logic [3:0]  group_count_next;
  logic        prev_was_separator_next;
  logic        gap_found_next;
  logic [2:0]  gap_position_next;
  status_t     error_code_next;

  logic        char_fire;
  logic        final_fire;
  logic [4:0]  hex;
  logic [3:0]  count_inc;
  logic [3:0]  tail_start;
  logic [2:0]  last;
  group_t      placed [GroupCount];
  addr_item_t  result;

  // Hold a final character only while a finished address is still untaken.
  assign char_ready = addr_ready || !addr_valid || !char_item.is_final;
  assign char_fire  = char_valid && char_ready;
  assign final_fire = char_fire && char_item.is_final;

  assign hex       = hex_decode(char_item.char_code);
  assign count_inc = group_count + 4'd1;

  // Per-character update. After an error, ignore everything until the final character.
  always_comb begin
    group_store_next        = group_store;
    group_count_next        = group_count;
    prev_was_separator_next = prev_was_separator;
    gap_found_next          = gap_found;
    gap_position_next       = gap_position;
    error_code_next         = error_code;
    if (error_code == STATUS_OK) begin
      if (hex[4]) begin
        // Shift the digit into the current group, keeping the low 16 bits.
        prev_was_separator_next = 1'b0;
        group_store_next[group_count[2:0]] =
          {group_store[group_count[2:0]][GroupWidth-5:0], hex[3:0]};
      end else begin
        group_count_next        = count_inc;
        prev_was_separator_next = 1'b1;
        if (prev_was_separator && gap_found) begin
          // Second gap wins over the character check.
          error_code_next = STATUS_TWO_GAP;
        end else begin
          if (prev_was_separator) begin
            gap_found_next    = 1'b1;
            gap_position_next = group_count[2:0];
          end
          if (char_item.char_code != CHAR_COLON || count_inc >= 4'(GroupCount)) begin
            error_code_next = STATUS_BAD;
          end
        end
      end
    end
  end

  // Final reorder: groups before the gap stay, groups after it move to the tail.
  assign last       = group_count_next[2:0];
  assign tail_start = 4'(GroupCount) + {1'b0, gap_position_next} - {1'b0, last};

  always_comb begin
    for (int p = 0; p < GroupCount; p++) begin
      placed[p] = '0;
      if (error_code_next == STATUS_OK) begin
        if (!gap_found_next) begin
          placed[p] = group_store_next[p];
        end else if (3'(p) < gap_position_next) begin
          placed[p] = group_store_next[p];
        end else if (4'(p) >= tail_start) begin
          // Source group index is p + last - 7, modulo 8.
          placed[p] = group_store_next[3'(p) + last + 3'd1];
        end
      end
    end
    result.address_high = {placed[0], placed[1], placed[2], placed[3]};
    result.address_low  = {placed[4], placed[5], placed[6], placed[7]};
    result.status       = error_code_next;
  end

  // Advance the parser; clear it after the final character.
  always_ff @(posedge clk) begin
    if (rst || final_fire) begin
      for (int g = 0; g < GroupCount; g++) begin
        group_store[g] <= '0;
      end
      group_count        <= '0;
      prev_was_separator <= 1'b0;
      gap_found          <= 1'b0;
      gap_position       <= '0;
      error_code         <= STATUS_OK;
    end else if (char_fire) begin
      group_store        <= group_store_next;
      group_count        <= group_count_next;
      prev_was_separator <= prev_was_separator_next;
      gap_found          <= gap_found_next;
      gap_position       <= gap_position_next;
      error_code         <= error_code_next;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      addr_valid <= 1'b0;
    end else if (final_fire) begin
      addr_valid <= 1'b1;
    end else if (addr_ready) begin
      addr_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (final_fire) begin
      addr_item <= result;
    end
  end

  // Status is never the unused code.
  assert property (@(posedge clk) disable iff (rst)
    addr_valid |-> (addr_item.status <= STATUS_TWO_GAP))
    else $error("undefined status on result");

  // An error result carries a zero address.
  assert property (@(posedge clk) disable iff (rst)
    (addr_valid && addr_item.status != STATUS_OK) |->
      (addr_item.address_high == '0 && addr_item.address_low == '0))
    else $error("error result with nonzero address");

  // A final character leaves the parser cleared.
  assert property (@(posedge clk) disable iff (rst)
    final_fire |=> (group_count == '0 && !gap_found && error_code == STATUS_OK))
    else $error("parser not cleared after final character");

  // Without an error, the gap lies before the current group.
  assert property (@(posedge clk) disable iff (rst)
    (gap_found && error_code == STATUS_OK) |-> ({1'b0, gap_position} < group_count))
    else $error("gap position beyond current group");

  // A final character is never taken over an untaken result.
  assert property (@(posedge clk) disable iff (rst)
    (addr_valid && !addr_ready) |=> $stable(addr_item))
    else $error("result overwritten while stalled");

endmodule

>>> tb/sv/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
  import ip6tp_pkg::*;

  // Character codes used to build address text.
  localparam logic [7:0] CH_ZERO    = 8'h30;
  localparam logic [7:0] CH_LOWER_A = 8'h61;
  localparam logic [7:0] CH_UPPER_A = 8'h41;

  localparam int TEXT_CHARS = 1900;  // stop random text after this many characters
  localparam int IDLE_LIMIT = 2000;  // cycles without any handshake before giving up
  localparam int DRAIN_CYCLES = 8;   // settle time after the last address

  // Parser shadow: tracks the group registers and flags character by character
  // and queues the address that each final character should produce.
  class addr_scoreboard;
    group_t     grp [GroupCount];
    logic [3:0] grp_idx;
    bit         after_sep;
    bit         gap_seen;
    logic [2:0] gap_at;
    status_t    err;
    addr_item_t addr_q [$];
    int         errors;

    function new();
      clear();
      errors = 0;
    endfunction

    function void clear();
      foreach (grp[i]) grp[i] = '0;
      grp_idx   = '0;
      after_sep = 1'b0;
      gap_seen  = 1'b0;
      gap_at    = '0;
      err       = STATUS_OK;
    endfunction

    function int nibble_of(logic [7:0] c);
      if (c >= CH_ZERO && c <= CH_ZERO + 8'd9) return int'(c - CH_ZERO);
      if (c >= CH_LOWER_A && c <= CH_LOWER_A + 8'd5) return int'(c - CH_LOWER_A) + 10;
      if (c >= CH_UPPER_A && c <= CH_UPPER_A + 8'd5) return int'(c - CH_UPPER_A) + 10;
      return -1;
    endfunction

    // Reorder the groups around the gap and pack them into the two halves.
    function addr_item_t assemble();
      group_t     placed [GroupCount];
      addr_item_t r;
      int         i;
      int         last;
      int         gp;
      foreach (placed[k]) placed[k] = '0;
      if (err == STATUS_OK) begin
        if (gap_seen) begin
          last = int'(grp_idx[2:0]);
          gp   = int'(gap_at);
          for (i = 0; i < gp; i++) placed[i] = grp[i];
          // groups after the empty one slide to the tail
          for (i = gp + 1; i <= last; i++) placed[i + 7 - last] = grp[i];
        end else begin
          foreach (placed[k]) placed[k] = grp[k];
        end
      end
      r.address_high = {placed[0], placed[1], placed[2], placed[3]};
      r.address_low  = {placed[4], placed[5], placed[6], placed[7]};
      r.status       = err;
      return r;
    endfunction

    // Note one accepted character request.
    function void note_char(char_item_t req);
      int d;
      if (err == STATUS_OK) begin
        d = nibble_of(req.char_code);
        if (d >= 0) begin
          after_sep = 1'b0;
          grp[grp_idx[2:0]] = {grp[grp_idx[2:0]][11:0], 4'(d)};
        end else begin
          grp_idx = grp_idx + 4'd1;
          if (after_sep && gap_seen) begin
            err = STATUS_TWO_GAP;
          end else begin
            // any non-digit right after a separator opens the gap
            if (after_sep) begin
              gap_seen = 1'b1;
              gap_at   = 3'(grp_idx - 4'd1);
            end
            after_sep = 1'b1;
            if (req.char_code != CHAR_COLON || grp_idx >= 4'(GroupCount)) err = STATUS_BAD;
          end
        end
      end
      if (req.is_final) begin
        addr_q.push_back(assemble());
        clear();
      end
    endfunction

    task report(string msg);
      if (errors < 50) $display("MISMATCH at %0t: %s", $time, msg);
      errors++;
    endtask

    // Check one accepted address request against the oldest pending one.
    task check_addr(addr_item_t got);
      addr_item_t want;
      if (addr_q.size() == 0) begin
        report($sformatf("address %h_%h status %0d with no text pending",
                         got.address_high, got.address_low, got.status));
        return;
      end
      want = addr_q.pop_front();
      if (got.address_high !== want.address_high)
        report($sformatf("address_high %h, want %h", got.address_high, want.address_high));
      if (got.address_low !== want.address_low)
        report($sformatf("address_low %h, want %h", got.address_low, want.address_low));
      if (got.status !== want.status)
        report($sformatf("status %0d, want %0d", got.status, want.status));
    endtask

    function int pending();
      return addr_q.size();
    endfunction
  endclass

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       char_valid = 1'b0;
  logic       char_ready;
  char_item_t char_item = '0;
  logic       addr_valid;
  logic       addr_ready = 1'b0;
  addr_item_t addr_item;

  addr_scoreboard sb = new();

  logic [7:0] txt [$];    // text of the address being sent
  int         chars_sent = 0;
  int         burst_left = 0;
  int         rx_cycle = 0;

  ipv6_text_address_parser dut (
    .clk        (clk),
    .rst        (rst),
    .char_valid (char_valid),
    .char_ready (char_ready),
    .char_item  (char_item),
    .addr_valid (addr_valid),
    .addr_ready (addr_ready),
    .addr_item  (addr_item)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Sender pacing: bursts of random length, each followed by a random gap.
  // Skip the gap now and then so that long back-to-back stretches happen too.
  task automatic pace();
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        char_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 40);
    end
    burst_left--;
  endtask

  // Present one character request and hold it until the parser takes it.
  task automatic send_char(char_item_t req);
    char_valid <= 1'b1;
    char_item  <= req;
    @(posedge clk);
    while (!char_ready) @(posedge clk);
    sb.note_char(req);
    chars_sent++;
  endtask

  // Send the text buffer, flagging its last character as final.
  task automatic send_text();
    char_item_t req;
    int         i;
    for (i = 0; i < txt.size(); i++) begin
      req.char_code = txt[i];
      req.is_final  = (i == txt.size() - 1);
      pace();
      send_char(req);
    end
  endtask

  function automatic void set_text(string s);
    int i;
    txt.delete();
    for (i = 0; i < s.len(); i++) txt.push_back(s[i]);
  endfunction

  function automatic logic [7:0] hex_char(int n);
    if (n < 10) return 8'(CH_ZERO + n);
    // mix upper and lower case letters
    return 8'(($urandom_range(0, 1) ? CH_LOWER_A : CH_UPPER_A) + n - 10);
  endfunction

  // Append one group; mostly 1-4 digits, sometimes enough to overflow 16 bits.
  function automatic void push_group();
    int n;
    int k;
    n = ($urandom_range(0, 7) == 0) ? $urandom_range(5, 6) : $urandom_range(1, 4);
    for (k = 0; k < n; k++) txt.push_back(hex_char($urandom_range(0, 15)));
  endfunction

  // Build a well-formed address: either plain groups, or a prefix, a gap
  // and a suffix with up to seven groups around it.
  function automatic void build_address();
    int n;
    int a;
    int k;
    txt.delete();
    if ($urandom_range(0, 1)) begin
      n = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 7) : GroupCount;
      for (k = 0; k < n; k++) begin
        if (k > 0) txt.push_back(CHAR_COLON);
        push_group();
      end
    end else begin
      n = $urandom_range(0, 7);
      a = $urandom_range(0, n);
      for (k = 0; k < a; k++) begin
        if (k > 0) txt.push_back(CHAR_COLON);
        push_group();
      end
      txt.push_back(CHAR_COLON);
      txt.push_back(CHAR_COLON);
      for (k = 0; k < n - a; k++) begin
        if (k > 0) txt.push_back(CHAR_COLON);
        push_group();
      end
    end
  endfunction

  // Break a good address: corrupt a character, add a separator, or add a group.
  function automatic void damage_address();
    int pos;
    build_address();
    pos = $urandom_range(0, txt.size() - 1);
    case ($urandom_range(0, 2))
      0: begin
        txt[pos] = 8'($urandom_range(0, 255));
      end
      1: begin
        txt.insert(pos, CHAR_COLON);
      end
      default: begin
        txt.push_back(CHAR_COLON);
        push_group();
      end
    endcase
  endfunction

  function automatic void build_noise();
    int n;
    txt.delete();
    n = $urandom_range(1, 6);
    repeat (n) txt.push_back(8'($urandom_range(0, 255)));
  endfunction

  // Receiver: take addresses and cycle through its own stall modes
  // (always ready, coin flip, short ready window, mostly ready).
  always @(posedge clk) begin
    if (!rst && addr_valid && addr_ready) sb.check_addr(addr_item);
    case ((rx_cycle / 256) % 4)
      0: addr_ready <= 1'b1;
      1: addr_ready <= 1'($urandom_range(0, 1));
      2: addr_ready <= ((rx_cycle % 8) < 2);
      default: addr_ready <= ($urandom_range(0, 3) != 0);
    endcase
    rx_cycle++;
  end

  // Watchdog: give up when no request moves on either side for too long.
  initial begin
    int idle;
    idle = 0;
    while (idle < IDLE_LIMIT) begin
      @(posedge clk);
      if ((char_valid && char_ready) || (addr_valid && addr_ready)) idle = 0;
      else idle++;
    end
    $display("Simulation FAILED");
    $finish;
  end

  initial begin
    bit paused;
    int pick;
    paused = 1'b0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Directed text: truncated group with no gap, mixed-case gap in the middle,
    // triple separator (second gap), bad characters at both code extremes with
    // the trailing one ignored, and an eighth separator after a leading empty group.
    set_text("12345");
    send_text();
    set_text("a::F");
    send_text();
    set_text(":::");
    send_text();
    txt.delete();
    txt.push_back(8'hFF);
    txt.push_back(8'h00);
    send_text();
    set_text(":1:2:3:4:5:6:7:");
    send_text();

    // Random text: mostly good addresses, the rest broken or pure noise.
    while (chars_sent < TEXT_CHARS) begin
      if (!paused && chars_sent >= TEXT_CHARS / 2) begin
        // hold off until every pending address has drained
        char_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge clk);
        paused = 1'b1;
        burst_left = 0;
      end
      pick = $urandom_range(0, 99);
      if (pick < 70) build_address();
      else if (pick < 85) damage_address();
      else build_noise();
      send_text();
    end
    char_valid <= 1'b0;

    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end

endmodule

>>> files.f
hw/rtl/ip6tp_pkg.sv
hw/rtl/ipv6_text_address_parser.sv
tb/sv/tb_top.sv
